>>> rtl/dbvp_pkg.sv
// Shared types, codes and the population count used by the vertex peeling block.
package dbvp_pkg;

  localparam int unsigned ROW_W    = 64;
  localparam int unsigned PERSON_W = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Input command codes.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PEOPLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KNOWN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_UNKNOWN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GROUP   = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SOLVE,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [PERSON_W-1:0] person_a;
    logic [PERSON_W-1:0] person_b;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]   invited_mask;
    logic [COUNT_W-1:0] invited_count;
  } out_word_t;

  typedef struct packed {
    op_kind_e            kind;
    logic [PERSON_W-1:0] a;
    logic [PERSON_W-1:0] b;
  } op_t;

  // Adder tree over the 64 bits of a row.
  function automatic logic [COUNT_W-1:0] popcount64(input logic [ROW_W-1:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

endpackage

>>> rtl/dbvp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dbvp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/dbvp_fifo.sv
// Short operation queue between the front classifier and the back engine.
module dbvp_fifo
  import dbvp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           slot_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/dbvp_front.sv
// Front end: classifies accepted words and drops those that have no effect.
module dbvp_front
  import dbvp_pkg::*;
(
  input  logic               accept_i,
  input  in_word_t           in_word_i,
  input  logic [COUNT_W-1:0] people_i,
  output logic               op_push_o,
  output op_t                op_o
);

  logic pair_ok;

  assign pair_ok = (in_word_i.person_a != in_word_i.person_b)
                && ({1'b0, in_word_i.person_a} < people_i)
                && ({1'b0, in_word_i.person_b} < people_i);

  always_comb begin
    op_o.a    = in_word_i.person_a;
    op_o.b    = in_word_i.person_b;
    op_o.kind = OP_ADD;
    op_push_o = 1'b0;
    case (in_word_i.command)
      CMD_ADD: begin
        op_push_o = accept_i && pair_ok;
      end
      CMD_SOLVE: begin
        op_o.kind = OP_SOLVE;
        op_push_o = accept_i;
      end
      CMD_CLEAR: begin
        op_o.kind = OP_CLEAR;
        op_push_o = accept_i;
      end
      default: begin
        op_push_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/dbvp_back.sv
// Back end: adjacency row memory, edge updates and the peeling sweep engine.
module dbvp_back
  import dbvp_pkg::*;
#(
  parameter int unsigned MAX_PEOPLE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  op_t                 op_i,
  output logic                op_pop_o,
  input  logic [COUNT_W-1:0]  people_i,
  input  logic [PERSON_W-1:0] min_known_i,
  input  logic [PERSON_W-1:0] min_unknown_i,
  input  logic [COUNT_W-1:0]  min_group_i,
  input  logic                pop_i,
  output logic                out_valid_o,
  output out_word_t           out_o
);

  localparam int unsigned AW = $clog2(MAX_PEOPLE);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD_A = 3'd1;
  localparam logic [2:0] ST_ADD_B = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CNT   = 3'd4;
  localparam logic [2:0] ST_DEC   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]            state_q, state_d;
  op_t                   op_q;
  logic [AW-1:0]         p_q, p_d;
  logic [ROW_W-1:0]      mask_q, mask_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [COUNT_W-1:0]    known_q;
  logic                  changed_q, changed_d;
  logic [MAX_PEOPLE-1:0] row_valid_q, row_valid_d;
  logic                  rd_valid_q;
  out_word_t             out_q;
  logic                  out_valid_q;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [ROW_W-1:0]      wdata, rdata, row;
  logic [ROW_W-1:0]      p_bit;
  logic [COUNT_W-1:0]    unknown;
  logic                  remove, load_out;

  dbvp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PEOPLE)) u_rows (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // A row never written since the last clear reads as no acquaintances.
  assign row     = rd_valid_q ? rdata : '0;
  assign p_bit   = ROW_W'(1) << p_q;
  assign unknown = count_q - known_q - COUNT_W'(1);
  assign remove  = mask_q[p_q] && ((known_q < {1'b0, min_known_i})
                                || (unknown < {1'b0, min_unknown_i}));
  assign op_pop_o = (state_q == ST_IDLE) && op_valid_i;
  assign load_out = (state_q == ST_FIN) && !out_valid_q;

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    mask_d      = mask_q;
    count_d     = count_q;
    changed_d   = changed_q;
    row_valid_d = row_valid_q;
    we          = 1'b0;
    waddr       = op_q.a[AW-1:0];
    wdata       = row | (ROW_W'(1) << op_q.b);
    raddr       = p_q;
    case (state_q)
      ST_IDLE: begin
        raddr = op_i.a[AW-1:0];
        if (op_valid_i) begin
          case (op_i.kind)
            OP_ADD: state_d = ST_ADD_A;
            OP_SOLVE: begin
              mask_d    = (ROW_W'(1) << people_i) - ROW_W'(1);
              count_d   = people_i;
              p_d       = '0;
              changed_d = 1'b0;
              state_d   = (people_i == '0) ? ST_FIN : ST_RD;
            end
            OP_CLEAR: row_valid_d = '0;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_A: begin
        we = 1'b1;
        row_valid_d[op_q.a[AW-1:0]] = 1'b1;
        raddr   = op_q.b[AW-1:0];
        state_d = ST_ADD_B;
      end
      ST_ADD_B: begin
        we    = 1'b1;
        waddr = op_q.b[AW-1:0];
        wdata = row | (ROW_W'(1) << op_q.a);
        row_valid_d[op_q.b[AW-1:0]] = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD: state_d = ST_CNT;
      ST_CNT: state_d = ST_DEC;
      ST_DEC: begin
        if (remove) begin
          mask_d  = mask_q & ~p_bit;
          count_d = count_q - COUNT_W'(1);
        end
        changed_d = changed_q || remove;
        if (COUNT_W'(p_q) == people_i - COUNT_W'(1)) begin
          p_d = '0;
          if (changed_q || remove) begin
            changed_d = 1'b0;
            state_d   = ST_RD;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          p_d     = p_q + AW'(1);
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
      changed_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      changed_q   <= changed_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    mask_q     <= mask_d;
    count_q    <= count_d;
    rd_valid_q <= row_valid_q[raddr];
    if (op_pop_o) begin
      op_q <= op_i;
    end
    if (state_q == ST_CNT) begin
      known_q <= popcount64(row & mask_q & ~p_bit);
    end
    if (load_out) begin
      if (count_q < min_group_i) begin
        out_q.invited_mask  <= '0;
        out_q.invited_count <= '0;
      end else begin
        out_q.invited_mask  <= mask_q;
        out_q.invited_count <= count_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/degree_bounded_vertex_peeling.sv
// Top level of the degree bounded vertex peeling block.
//
//  channel   handshake         word
//  input     push / full       in_word_i  (command, person_a, person_b)
//  result    empty / pop       out_word_o (invited_mask, invited_count)
//  config    cfg_we_i          cfg_idx_i, cfg_data_i
//
// An add writes the rows of both people in turn and a clear drops all rows; the queue holds
// two words ahead. A solve sweeps over the people in use, reading, counting and deciding for
// each person in turn, one sweep for each sweep that removes someone plus a final clean sweep;
// the single row memory read port sets this. Reset empties the graph at once via per-row valid bits.
// Full is high while the operation queue is full. A result still waiting when the next solve
// finishes holds the back end there, so the queue can fill up and stall the input.
module degree_bounded_vertex_peeling
  import dbvp_pkg::*;
#(
  parameter int unsigned MAX_PEOPLE = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_word_t             in_word_i,
  output logic                 empty,
  input  logic                 pop,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [COUNT_W-1:0]  people_q;
  logic [PERSON_W-1:0] min_known_q, min_unknown_q;
  logic [COUNT_W-1:0]  min_group_q;
  logic [COUNT_W-1:0]  people_eff;
  logic                op_push, op_pop, q_full, q_empty, out_valid;
  op_t                 op_in, op_out;

  assign people_eff = (people_q > COUNT_W'(MAX_PEOPLE)) ? COUNT_W'(MAX_PEOPLE) : people_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      people_q      <= COUNT_W'(64);
      min_known_q   <= PERSON_W'(5);
      min_unknown_q <= PERSON_W'(5);
      min_group_q   <= COUNT_W'(11);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PEOPLE:      people_q      <= cfg_data_i;
        CFG_MIN_KNOWN:   min_known_q   <= cfg_data_i[PERSON_W-1:0];
        CFG_MIN_UNKNOWN: min_unknown_q <= cfg_data_i[PERSON_W-1:0];
        CFG_MIN_GROUP:   min_group_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dbvp_front u_front (
    .accept_i (push && !full),
    .in_word_i(in_word_i),
    .people_i (people_eff),
    .op_push_o(op_push),
    .op_o     (op_in)
  );

  dbvp_fifo #(.DEPTH(2)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .data_i (op_in),
    .full_o (q_full),
    .pop_i  (op_pop),
    .empty_o(q_empty),
    .data_o (op_out)
  );

  dbvp_back #(.MAX_PEOPLE(MAX_PEOPLE)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (!q_empty),
    .op_i         (op_out),
    .op_pop_o     (op_pop),
    .people_i     (people_eff),
    .min_known_i  (min_known_q),
    .min_unknown_i(min_unknown_q),
    .min_group_i  (min_group_q),
    .pop_i        (pop),
    .out_valid_o  (out_valid),
    .out_o        (out_word_o)
  );

  assign full  = q_full;
  assign empty = !out_valid;

endmodule

>>> rtl/dbvp_checker.sv
// Port level checks for the vertex peeling block and their binding.
module dbvp_checker
  import dbvp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word_o
);

  // The count shown with a result always matches the invited mask.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(out_word_o.invited_count) == $countones(out_word_o.invited_mask)))
    else $error("invited_count does not match invited_mask");

  // A waiting result word holds until it is popped.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("result word changed before pop");

  // Reset leaves no result and a queue with room.
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("block not idle under reset");

endmodule

bind degree_bounded_vertex_peeling dbvp_checker u_dbvp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_word_o(out_word_o)
);
